@@ hw/rtl/hds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants for the heat diffusion stencil step
// fixed field widths, register indexes, arithmetic widths and queue sizing
// ----------------------------------------------------------------------------
package hds_pkg;

  // field widths
  localparam int TEMP_W       = 16;
  localparam int GAIN_W       = 15;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 13;
  localparam int CFG_DATA_W   = 15;
  localparam int CFG_ADDR_W   = 2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DIFF_GAIN   = 2'd2;

  // register reset values
  localparam logic [CFG_WIDTH_W-1:0]  GRID_WIDTH_RST  = 11'd64;
  localparam logic [CFG_HEIGHT_W-1:0] GRID_HEIGHT_RST = 13'd64;
  localparam logic [GAIN_W-1:0]       DIFF_GAIN_RST   = 15'd4096;

  // smallest usable grid dimension
  localparam int MIN_DIM = 3;

  // arithmetic widths
  localparam int LAP_W      = TEMP_W + 3;          // signed laplacian
  localparam int PROD_W     = LAP_W + GAIN_W + 1;  // gain * laplacian
  localparam int FRAC_SHIFT = 16;                  // q8.24 -> q8.8
  localparam int DELTA_W    = LAP_W;
  localparam int VAL_W      = TEMP_W + 4;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

endpackage

@@ hw/rtl/heat_diffusion_stencil_step.sv @@
`timescale 1ns / 1ps
// result path: the cell completing a result word passes the buffer read, queue,
//   multiply, round and saturate steps before the word is valid
// throughput: one cell per cycle when ready, set by the single write port of each line buffer
// reset: synchronous, active low; clears counters, window and valid flags,
//   loads the register defaults; line buffers are not cleared
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step: one explicit 5-point heat diffusion time step
// streams a raster grid in and emits updated interior cells
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_step
  import hds_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic clk,
  input  logic rst_n,

  // cell words in raster order
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [TEMP_W-1:0] in_tdata,  // [15:0] cell_temp
  input  logic [0:0]        in_tuser,  // [0] frame_start

  // updated interior cells
  output logic out_tvalid,
  input  logic out_tready,
  // [15:0] new_temp, then cell_col, then cell_row, zero padded to bytes
  output logic [((TEMP_W+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+7)/8)*8-1:0] out_tdata,
  output logic out_tlast,  // frame_last

  // register writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WORK_W = LAP_W + TEMP_W + COL_W + ROW_W + 1;
  localparam int OUT_W  = ((TEMP_W + COL_W + ROW_W + 7) / 8) * 8;

  // configuration registers
  logic [CFG_WIDTH_W-1:0]  grid_width_r;
  logic [CFG_HEIGHT_W-1:0] grid_height_r;
  logic [GAIN_W-1:0]       diffusion_gain_r;

  // clamped grid size
  logic [COL_W:0] w_eff;
  logic [ROW_W:0] h_eff;

  // queue hookup
  logic               q_push, q_pop, q_empty;
  logic [WORK_W-1:0]  q_wdata, q_rdata;
  logic [Q_CNT_W-1:0] q_count;

  // result fields
  logic [TEMP_W-1:0] res_temp;
  logic [COL_W-1:0]  res_col;
  logic [ROW_W-1:0]  res_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r     <= GRID_WIDTH_RST;
      grid_height_r    <= GRID_HEIGHT_RST;
      diffusion_gain_r <= DIFF_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GRID_WIDTH:  grid_width_r     <= cfg_wdata[CFG_WIDTH_W-1:0];
        REG_GRID_HEIGHT: grid_height_r    <= cfg_wdata[CFG_HEIGHT_W-1:0];
        REG_DIFF_GAIN:   diffusion_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // width and height used clamped to 3..max
  always_comb begin
    if (32'(grid_width_r) < 32'(MIN_DIM)) begin
      w_eff = (COL_W+1)'(MIN_DIM);
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(grid_width_r);
    end
    if (32'(grid_height_r) < 32'(MIN_DIM)) begin
      h_eff = (ROW_W+1)'(MIN_DIM);
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (ROW_W+1)'(grid_height_r);
    end
  end

  // front: positions cells, keeps the two line buffers, builds the laplacian
  hds_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .in_valid(in_tvalid),
    .in_temp (in_tdata),
    .in_start(in_tuser[0]),
    .in_ready(in_tready),
    .q_count (q_count),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // queue: lets the front keep taking words while results back up
  hds_queue #(
    .DATA_W(WORK_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty),
    .count    (q_count)
  );

  // back: multiply, round, saturate and hold the result word
  hds_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .gain     (diffusion_gain_r),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res_temp (res_temp),
    .res_col  (res_col),
    .res_row  (res_row),
    .res_last (out_tlast)
  );

  assign out_tdata = OUT_W'({res_row, res_col, res_temp});

endmodule

@@ hw/rtl/hds_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_queue: short work queue between front and back
// small register fifo, head word visible combinationally
// ----------------------------------------------------------------------------
module hds_queue
  import hds_pkg::*;
#(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty,
  output logic [Q_CNT_W-1:0] count
);

  logic [DATA_W-1:0]  slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hw/rtl/hds_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_front: raster counters, line buffers and stencil gather
// places each word on the grid, reads its neighbors and queues interior work
// ----------------------------------------------------------------------------
module hds_front
  import hds_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic clk,
  input  logic rst_n,
  // grid size, already clamped
  input  logic [$clog2(MAX_WIDTH):0]  w_eff,
  input  logic [$clog2(MAX_HEIGHT):0] h_eff,
  // input words
  input  logic                        in_valid,
  input  logic [TEMP_W-1:0]           in_temp,
  input  logic                        in_start,
  output logic                        in_ready,
  // work queue
  input  logic [Q_CNT_W-1:0]          q_count,
  output logic                        q_push,
  // {last, row, col, centre, laplacian} from msb down
  output logic [LAP_W+TEMP_W+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0] q_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // line buffers
  logic [TEMP_W-1:0] row_above     [MAX_WIDTH];
  logic [TEMP_W-1:0] row_two_above [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  logic             accept;
  logic [COL_W-1:0] c_base, c_cur, c_right;
  logic [ROW_W-1:0] r_base, r_cur;
  logic [COL_W:0]   c_plus1, c_plus2;
  logic [ROW_W:0]   r_inc, r_plus1;
  logic             col_wrap, right_ok, interior, last;

  // stage after the buffer reads
  logic                  s1_valid_r;
  logic [COL_W-1:0]      s1_col_r;
  logic [ROW_W-1:0]      s1_row_r;
  logic                  s1_interior_r, s1_last_r, s1_right_ok_r;
  logic [TEMP_W-1:0]     s1_temp_r;
  logic [TEMP_W-1:0]     centre_rd_r, right_rd_r, up_rd_r, fwd_data_r;
  logic                  fwd_hit_r;
  logic [TEMP_W-1:0]     left_r;
  logic [TEMP_W-1:0]     up_val, right_val;
  logic [LAP_W-2:0]      nb_sum;
  logic signed [LAP_W-1:0] lap;

  assign in_ready = ({1'b0, q_count} + {{Q_CNT_W{1'b0}}, s1_valid_r})
                    < (Q_CNT_W+1)'(Q_DEPTH);
  assign accept   = in_valid && in_ready;

  // position of the arriving word
  always_comb begin
    c_base   = in_start ? '0 : col_r;
    r_base   = in_start ? '0 : row_r;
    col_wrap = ({1'b0, c_base} >= w_eff);
    c_cur    = col_wrap ? '0 : c_base;
    r_inc    = col_wrap ? {1'b0, r_base} + 1'b1 : {1'b0, r_base};
    r_cur    = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    c_plus1  = {1'b0, c_cur} + 1'b1;
    c_plus2  = {1'b0, c_cur} + (COL_W+1)'(2);
    r_plus1  = {1'b0, r_cur} + 1'b1;
    c_right  = c_plus1[COL_W-1:0];
    right_ok = (c_plus1 < w_eff);
    interior = (r_cur >= ROW_W'(2)) && (c_cur != '0) && right_ok;
    last     = (c_plus2 == w_eff) && (r_plus1 == h_eff);
    // advance past this word
    col_nxt  = right_ok ? c_plus1[COL_W-1:0] : '0;
    row_nxt  = r_cur;
    if (!right_ok) begin
      row_nxt = (r_plus1 >= h_eff) ? '0 : r_plus1[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      left_r     <= '0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      // window shifts once per word
      if (s1_valid_r) begin
        left_r <= centre_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r      <= c_cur;
      s1_row_r      <= r_cur - 1'b1;
      s1_interior_r <= interior;
      s1_last_r     <= last;
      s1_right_ok_r <= right_ok;
      s1_temp_r     <= in_temp;
      // pending row_two_above write of the previous word at this column
      fwd_hit_r     <= s1_valid_r && (s1_col_r == c_cur);
      fwd_data_r    <= centre_rd_r;
    end
  end

  // row_above: read first at two columns, then written with the new word
  always_ff @(posedge clk) begin
    if (accept) begin
      centre_rd_r       <= row_above[c_cur];
      right_rd_r        <= row_above[c_right];
      row_above[c_cur]  <= in_temp;
    end
  end

  // row_two_above: takes the old row_above entry in the cycle after the read
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd_r <= row_two_above[c_cur];
    end
    if (s1_valid_r) begin
      row_two_above[s1_col_r] <= centre_rd_r;
    end
  end

  always_comb begin
    up_val    = fwd_hit_r ? fwd_data_r : up_rd_r;
    right_val = s1_right_ok_r ? right_rd_r : '0;
    nb_sum    = (LAP_W-1)'(left_r) + (LAP_W-1)'(right_val)
              + (LAP_W-1)'(up_val) + (LAP_W-1)'(s1_temp_r);
    lap       = $signed({1'b0, nb_sum}) - $signed({1'b0, centre_rd_r, 2'b00});
  end

  assign q_push = s1_valid_r && s1_interior_r;
  assign q_data = {s1_last_r, s1_row_r, s1_col_r, centre_rd_r, lap};

endmodule

@@ hw/rtl/hds_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_back: update arithmetic and result register
// gain multiply, round to q8.8, add to centre, saturate
// ----------------------------------------------------------------------------
module hds_back
  import hds_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [GAIN_W-1:0] gain,
  // work queue
  input  logic              q_empty,
  input  logic [LAP_W+TEMP_W+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT):0] q_data,
  output logic              q_pop,
  // results
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [TEMP_W-1:0]             res_temp,
  output logic [$clog2(MAX_WIDTH)-1:0]  res_col,
  output logic [$clog2(MAX_HEIGHT)-1:0] res_row,
  output logic                          res_last
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CEN_LO = LAP_W;
  localparam int COL_LO = CEN_LO + TEMP_W;
  localparam int ROW_LO = COL_LO + COL_W;
  localparam int LST_B  = ROW_LO + ROW_W;

  logic en;

  // multiply stage
  logic                     m_valid_r;
  logic signed [PROD_W-1:0] m_prod_r;
  logic [TEMP_W-1:0]        m_centre_r;
  logic [COL_W-1:0]         m_col_r;
  logic [ROW_W-1:0]         m_row_r;
  logic                     m_last_r;

  // rounding stage
  logic                      d_valid_r;
  logic signed [DELTA_W-1:0] d_delta_r;
  logic [TEMP_W-1:0]         d_centre_r;
  logic [COL_W-1:0]          d_col_r;
  logic [ROW_W-1:0]          d_row_r;
  logic                      d_last_r;

  // result register
  logic              out_valid_r;
  logic [TEMP_W-1:0] out_temp_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_last_r;

  logic signed [LAP_W-1:0]  q_lap;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic signed [VAL_W-1:0]  val;
  logic [TEMP_W-1:0]        sat;

  assign en    = !out_valid_r || res_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    q_lap   = $signed(q_data[LAP_W-1:0]);
    prod    = $signed({1'b0, gain}) * q_lap;
    rounded = m_prod_r + $signed(ROUND_HALF);
    shifted = rounded >>> FRAC_SHIFT;
    val     = $signed({{(VAL_W-TEMP_W){1'b0}}, d_centre_r})
            + $signed({{(VAL_W-DELTA_W){d_delta_r[DELTA_W-1]}}, d_delta_r});
    if (val[VAL_W-1]) begin
      sat = '0;
    end else if (val[VAL_W-2:TEMP_W] != '0) begin
      sat = '1;
    end else begin
      sat = val[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r   <= q_pop;
      d_valid_r   <= m_valid_r;
      out_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod_r   <= prod;
      m_centre_r <= q_data[COL_LO-1:CEN_LO];
      m_col_r    <= q_data[ROW_LO-1:COL_LO];
      m_row_r    <= q_data[LST_B-1:ROW_LO];
      m_last_r   <= q_data[LST_B];

      d_delta_r  <= shifted[DELTA_W-1:0];
      d_centre_r <= m_centre_r;
      d_col_r    <= m_col_r;
      d_row_r    <= m_row_r;
      d_last_r   <= m_last_r;

      out_temp_r <= sat;
      out_col_r  <= d_col_r;
      out_row_r  <= d_row_r;
      out_last_r <= d_last_r;
    end
  end

  assign res_valid = out_valid_r;
  assign res_temp  = out_temp_r;
  assign res_col   = out_col_r;
  assign res_row   = out_row_r;
  assign res_last  = out_last_r;

endmodule

@@ hw/rtl/hds_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hds_checker: port-level checks for the stencil step
// watches the stream ports over time, bound to the top level
// ----------------------------------------------------------------------------
module hds_checker
  import hds_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [((TEMP_W+$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+7)/8)*8-1:0] out_tdata,
  input logic              out_tlast
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_LO = TEMP_W;
  localparam int ROW_LO = TEMP_W + COL_W;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // only interior cells come out
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[ROW_LO-1:COL_LO] != '0) &&
                   (out_tdata[ROW_LO+ROW_W-1:ROW_LO] != '0))
    else $error("boundary cell emitted");

  // nothing pending right after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result word valid straight after reset");

  // empty queue after reset takes words at once
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_tready)
    else $error("input not ready straight after reset");

endmodule

bind heat_diffusion_stencil_step hds_checker #(
  .MAX_WIDTH (MAX_WIDTH),
  .MAX_HEIGHT(MAX_HEIGHT)
) u_hds_checker (.*);

@@ tb/sv/tb_heat_diffusion_stencil_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heat_diffusion_stencil_step: self-checking bench for the stencil step
// streams directed and random grids through the block, predicts each updated
// interior cell as cell words are accepted and checks every result word
// ----------------------------------------------------------------------------
module tb_heat_diffusion_stencil_step
  import hds_pkg::*;
();

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int COL_W         = $clog2(MAX_W);
  localparam int ROW_W         = $clog2(MAX_H);
  localparam int OUT_W         = ((TEMP_W + COL_W + ROW_W + 7) / 8) * 8;
  localparam int SETTLE_CYCLES = 8;     // margin after the last expected result
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD     = 300;   // receiver hold-off that backs up the block
  localparam int RANDOM_CELLS  = 800;

  typedef enum int {TEMP_UNIFORM, TEMP_SMOOTH, TEMP_EXTREME} temp_mode_t;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic              start;
  } cell_word_t;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
  } cell_update_t;

  // ---------------------------------------------------------------------------
  // block ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TEMP_W-1:0]     in_tdata  = '0;  // [15:0] cell_temp
  logic [0:0]            in_tuser  = '0;  // [0] frame_start
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;       // [15:0] new_temp, [25:16] cell_col, [37:26] cell_row
  logic                  out_tlast;       // frame_last
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  heat_diffusion_stencil_step #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  cell_word_t   pending_cells[$];   // words waiting for the driver
  cell_update_t expected_cells[$];  // predicted updates, oldest first
  cell_update_t next_update;
  int           mismatches   = 0;
  int           send_gap     = 0;
  int           stall_left   = 0;
  int           holds_asked  = 0;   // written by the sequence only
  int           holds_served = 0;
  int           quiet_cycles = 0;
  bit           steady_in    = 1'b0;
  bit           steady_out   = 1'b0;

  // predictor copy of the registers and the block state
  logic [CFG_WIDTH_W-1:0]  width_reg  = GRID_WIDTH_RST;
  logic [CFG_HEIGHT_W-1:0] height_reg = GRID_HEIGHT_RST;
  logic [GAIN_W-1:0]       gain_reg   = DIFF_GAIN_RST;
  logic [TEMP_W-1:0]       line_above     [MAX_W];
  logic [TEMP_W-1:0]       line_two_above [MAX_W];
  int unsigned             col_pos     = 0;
  int unsigned             row_pos     = 0;
  logic [TEMP_W-1:0]       last_centre = '0;  // becomes the left neighbor

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // one accepted cell word: move the raster position, maybe complete the cell above
  function automatic void advance_stencil(logic [TEMP_W-1:0] temp, logic start);
    int unsigned       w, h, c, r;
    logic [TEMP_W-1:0] centre, right, up;
    longint            lap, delta, val;
    cell_update_t      upd;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a shrunk grid can leave the position outside it
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    centre = line_above[c];
    right  = (c + 1 < w) ? line_above[c + 1] : '0;
    up     = line_two_above[c];
    if (r >= 2 && c >= 1 && c + 2 <= w) begin
      lap = longint'(last_centre) + longint'(right) + longint'(up) + longint'(temp)
            - 4 * longint'(centre);
      // q8.24 product rounded half up to q8.8, floor through the arithmetic shift
      delta = (longint'(gain_reg) * lap + 32768) >>> 16;
      val   = longint'(centre) + delta;
      if (val < 0) val = 0;
      if (val > 65535) val = 65535;
      upd.temp = val[TEMP_W-1:0];
      upd.col  = c[COL_W-1:0];
      upd.row  = ROW_W'(r - 1);
      upd.last = (c == w - 2) && (r - 1 == h - 2);
      expected_cells.push_back(upd);
    end
    last_centre       = centre;
    line_two_above[c] = line_above[c];
    line_above[c]     = temp;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [TEMP_W-1:0] pick_temp(temp_mode_t mode, int base);
    int v;
    case (mode)
      TEMP_SMOOTH: begin
        v = base + int'($urandom_range(0, 1024)) - 512;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[TEMP_W-1:0];
      end
      TEMP_EXTREME: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return TEMP_W'($urandom_range(0, 65535));
        endcase
      end
      default: return TEMP_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 19))
      0: return $urandom_range(0, 2);
      1: return $urandom_range(13, 40);
      default: return $urandom_range(3, 12);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 19))
      0: return $urandom_range(0, 2);
      1: return $urandom_range(11, 24);
      default: return $urandom_range(3, 10);
    endcase
  endfunction

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16384;
      2: return 32767;
      3, 4: return $urandom_range(0, 32767);
      default: return $urandom_range(0, 16384);
    endcase
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %0d: %s got %0d want %0d", mismatches + 1, what, got, want);
    mismatches++;
  endtask

  task automatic queue_cell(logic [TEMP_W-1:0] temp, logic start);
    cell_word_t wd;
    wd.temp  = temp;
    wd.start = start;
    pending_cells.push_back(wd);
  endtask

  // raster cells, frame_start on most frame boundaries; noisy adds stray restarts
  task automatic queue_grid_cells(int n_cells, bit restart, bit noisy, temp_mode_t mode);
    int unsigned frame_len;
    int          base;
    bit          start;
    frame_len = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
    base = $urandom_range(0, 65535);
    for (int i = 0; i < n_cells; i++) begin
      start = (i == 0 && restart) ||
              (i % frame_len == 0 && $urandom_range(0, 99) < 85) ||
              (noisy && $urandom_range(0, 63) == 0);
      queue_cell(pick_temp(mode, base), start);
    end
  endtask

  // register write while the block is idle, predictor follows
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int unsigned value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      REG_GRID_WIDTH:  width_reg  = value[CFG_WIDTH_W-1:0];
      REG_GRID_HEIGHT: height_reg = value[CFG_HEIGHT_W-1:0];
      REG_DIFF_GAIN:   gain_reg   = value[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // a wider row mid-frame would read line buffer entries never written,
  // so such a change restarts the frame; returns whether it must
  function automatic bit width_needs_restart(int unsigned value);
    return clamp_dim(value, MAX_W) > clamp_dim(width_reg, MAX_W) &&
           (col_pos != 0 || row_pos != 0);
  endfunction

  // every word sent, every result seen, then a settle margin for trailing cells
  task automatic wait_drained();
    while (pending_cells.size() != 0 || in_tvalid || expected_cells.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // cell driver: pops the pending queue, random gaps between words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap > 0 || pending_cells.size() == 0) begin
        in_tvalid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_cells[0].temp;
        in_tuser  <= pending_cells[0].start;
        void'(pending_cells.pop_front());
        send_gap  <= (steady_in || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      end
    end
  end

  // accepted cell words feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) advance_stencil(in_tdata, in_tuser[0]);
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus the long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      stall_left   <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      out_tready   <= 1'b0;
      stall_left   <= LONG_HOLD;
      holds_served <= holds_asked;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (!steady_out && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  // result checker: each word against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cells.size() == 0) begin
        flag_mismatch("unexpected word, new_temp", out_tdata[TEMP_W-1:0], -1);
      end else begin
        next_update = expected_cells.pop_front();
        if (out_tdata[TEMP_W-1:0] !== next_update.temp)
          flag_mismatch("new_temp", out_tdata[TEMP_W-1:0], next_update.temp);
        if (out_tdata[TEMP_W+COL_W-1:TEMP_W] !== next_update.col)
          flag_mismatch("cell_col", out_tdata[TEMP_W+COL_W-1:TEMP_W], next_update.col);
        if (out_tdata[TEMP_W+COL_W+ROW_W-1:TEMP_W+COL_W] !== next_update.row)
          flag_mismatch("cell_row", out_tdata[TEMP_W+COL_W+ROW_W-1:TEMP_W+COL_W],
                        next_update.row);
        if (out_tlast !== next_update.last)
          flag_mismatch("frame_last", out_tlast, next_update.last);
      end
    end
  end

  // watchdog: too long without any handshake or register write
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("tb_heat_diffusion_stencil_step NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          random_cells;
    int unsigned w_new, h_new, frame_len;
    int          frames, n_cells;
    bit          restart;
    random_cells = 0;
    for (int i = 0; i < MAX_W; i++) begin
      line_above[i]     = '0;
      line_two_above[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // default registers: three rows of a 64 wide grid, no frame_start needed
    queue_grid_cells(3 * 64, 1'b0, 1'b0, TEMP_UNIFORM);
    wait_drained();

    // smallest grid through clamping, gain past the stable range;
    // row 3 of the old grid lies beyond the new height and wraps
    write_reg(REG_GRID_WIDTH, 0);
    write_reg(REG_GRID_HEIGHT, 2);
    write_reg(REG_DIFF_GAIN, 32767);
    // cold centre in a hot ring saturates high
    for (int i = 0; i < 9; i++) queue_cell((i == 4) ? 16'h0000 : 16'hFFFF, 1'b0);
    // next frame by wrap alone: hot centre in a cold ring saturates low
    for (int i = 0; i < 9; i++) queue_cell((i == 4) ? 16'hFFFF : 16'h0000, 1'b0);
    wait_drained();

    // back pressure: receiver holds off while the sender keeps offering
    write_reg(REG_GRID_WIDTH, 8);
    write_reg(REG_GRID_HEIGHT, 8);
    write_reg(REG_DIFF_GAIN, 8192);
    steady_in = 1'b1;
    holds_asked++;
    queue_grid_cells(2 * 64, 1'b1, 1'b0, TEMP_SMOOTH);
    random_cells += 2 * 64;
    wait_drained();

    // random settings, mostly whole frames with random content
    while (random_cells < RANDOM_CELLS) begin
      restart = 1'b0;
      if ($urandom_range(0, 2) != 0) begin
        w_new = pick_width();
        restart |= width_needs_restart(w_new);
        write_reg(REG_GRID_WIDTH, w_new);
      end
      if ($urandom_range(0, 2) != 0) begin
        h_new = pick_height();
        write_reg(REG_GRID_HEIGHT, h_new);
      end
      if ($urandom_range(0, 1) != 0) write_reg(REG_DIFF_GAIN, pick_gain());
      steady_in  = ($urandom_range(0, 4) == 0);
      steady_out = ($urandom_range(0, 4) == 0);
      frame_len = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
      frames  = (frame_len <= 150) ? $urandom_range(0, 3) : 0;
      // partial frames leave the position mid-grid for the next setting
      n_cells = frames * frame_len + $urandom_range(1, frame_len);
      queue_grid_cells(n_cells, restart, 1'b1, temp_mode_t'($urandom_range(0, 2)));
      random_cells += n_cells;
      wait_drained();
    end

    // widest row through clamping: one full row and the start of the next
    steady_in  = 1'b0;
    steady_out = 1'b0;
    write_reg(REG_GRID_WIDTH, 2047);
    write_reg(REG_GRID_HEIGHT, 3);
    write_reg(REG_DIFF_GAIN, pick_gain());
    queue_grid_cells(MAX_W + 8, 1'b1, 1'b0, TEMP_UNIFORM);
    wait_drained();

    // tall grid through clamping, first rows only
    write_reg(REG_GRID_WIDTH, 3);
    write_reg(REG_GRID_HEIGHT, 8191);
    write_reg(REG_DIFF_GAIN, 16384);
    queue_grid_cells(3 * 8, 1'b1, 1'b0, TEMP_SMOOTH);
    wait_drained();

    if (expected_cells.size() != 0)
      flag_mismatch("results never seen", expected_cells.size(), 0);
    if (mismatches == 0) begin
      $display("tb_heat_diffusion_stencil_step OK");
    end else begin
      $display("tb_heat_diffusion_stencil_step NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/hds_pkg.sv
hw/rtl/hds_queue.sv
hw/rtl/hds_front.sv
hw/rtl/hds_back.sv
hw/rtl/heat_diffusion_stencil_step.sv
hw/rtl/hds_checker.sv
tb/sv/tb_heat_diffusion_stencil_step.sv
